// ===== rtl/torq_pkg.sv =====
package torq_pkg;

  // default number of stored descriptors
  localparam int unsigned DefaultDepth = 16;
  // most entries one service may release
  localparam int unsigned MaxResults = 16;

  // request codes; code 3 is unused and only acknowledged
  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_SERVICE = 2'd1,
    REQ_FLUSH   = 2'd2
  } req_e;

  // result kind and status codes
  localparam logic KindAck     = 1'b0;
  localparam logic KindRelease = 1'b1;
  localparam logic StatusOk    = 1'b0;
  localparam logic StatusFull  = 1'b1;

  // one stored message descriptor
  typedef struct packed {
    logic [31:0] tm;
    logic [7:0]  sender;
    logic [15:0] tag;
    logic [15:0] size;
  } entry_t;

  // one result transaction
  typedef struct packed {
    logic        kind;
    logic        status;
    logic [7:0]  sender;
    logic [15:0] tag;
    logic [15:0] size;
    logic [31:0] tm;
    logic        last;
  } res_t;

endpackage

// ===== rtl/timestamp_ordered_release_queue.sv =====
// Sorted store of up to DEPTH message descriptors kept in a ring in one
// synchronous memory. A command is taken when start is high and busy is low.
// Flush, an unused request code, a rejected insert, an insert into an empty
// store and a service that does not act finish at once; their
// acknowledgement appears in the following cycle.
// An insert walks back from the tail through the memory read port, one entry
// per cycle, moving each entry that sorts after the new one up one place.
// A service that acts reads the head entries one per cycle and releases at
// most 16 of them; released entries come out one per cycle, oldest first,
// with last set on the final one. Every result is on the ports for a single
// cycle with strobe_o high and cannot be held off. No clearing pass is
// needed after reset.
module timestamp_ordered_release_queue
  import torq_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] send_time_i,
  input  logic [31:0] offset_time_i,
  input  logic [7:0]  sender_id_i,
  input  logic [15:0] payload_tag_i,
  input  logic [15:0] payload_size_i,
  input  logic [31:0] recv_time_i,
  input  logic        time_rolling_i,
  output logic        strobe_o,
  output logic        kind_o,
  output logic        status_o,
  output logic [7:0]  out_sender_o,
  output logic [15:0] out_tag_o,
  output logic [15:0] out_size_o,
  output logic [31:0] out_time_o,
  output logic        last_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic          re;
  logic [AW-1:0] raddr;
  entry_t        rdata;
  logic          res_valid;
  res_t          res;
  logic [CW-1:0] count;

  logic          strobe_q;
  res_t          res_q;

  torq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  torq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .req_type_i     (req_type_i),
    .send_time_i    (send_time_i),
    .offset_time_i  (offset_time_i),
    .sender_id_i    (sender_id_i),
    .payload_tag_i  (payload_tag_i),
    .payload_size_i (payload_size_i),
    .recv_time_i    (recv_time_i),
    .time_rolling_i (time_rolling_i),
    .we_o           (we),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .re_o           (re),
    .raddr_o        (raddr),
    .rdata_i        (rdata),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .count_o        (count)
  );

  // result output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign strobe_o     = strobe_q;
  assign kind_o       = res_q.kind;
  assign status_o     = res_q.status;
  assign out_sender_o = res_q.sender;
  assign out_tag_o    = res_q.tag;
  assign out_size_o   = res_q.size;
  assign out_time_o   = res_q.tm;
  assign last_o       = res_q.last;

  // fill count stays within the store
  assert property (@(posedge clk_i) disable iff (!rst_ni) count <= CW'(DEPTH))
    else $error("fill count exceeds depth");

  // an accepted command either keeps working or answers next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) start && !busy |=> busy || strobe_o)
    else $error("accepted command dropped");

  // a result that is not the final one means the sequencer is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni) strobe_o && !last_o |-> busy)
    else $error("release burst ended without a final result");

  // an acknowledgement is always the single, final result of its command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   strobe_o && (kind_o == KindAck) |-> last_o)
    else $error("acknowledgement without last");

endmodule

// ===== rtl/torq_mem.sv =====
module torq_mem
  import torq_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered output
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/torq_ctrl.sv =====
module torq_ctrl
  import torq_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  logic [1:0]    req_type_i,
  input  logic [31:0]   send_time_i,
  input  logic [31:0]   offset_time_i,
  input  logic [7:0]    sender_id_i,
  input  logic [15:0]   payload_tag_i,
  input  logic [15:0]   payload_size_i,
  input  logic [31:0]   recv_time_i,
  input  logic          time_rolling_i,
  // memory side
  output logic          we_o,
  output logic [AW-1:0] waddr_o,
  output entry_t        wdata_o,
  output logic          re_o,
  output logic [AW-1:0] raddr_o,
  input  entry_t        rdata_i,
  // result side
  output logic          res_valid_o,
  output res_t          res_o,
  output logic [CW-1:0] count_o
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_INSERT  = 4'b0010,
    S_PUT     = 4'b0100,
    S_RELEASE = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] head_q, head_d;
  logic [31:0]   prev_q, prev_d;
  logic [31:0]   recv_q, recv_d;
  entry_t        new_q, new_d;
  logic [AW-1:0] k_q, k_d;
  logic [CW-1:0] idx_q, idx_d;
  entry_t        pend_q, pend_d;
  logic          pend_v_q, pend_v_d;

  entry_t        entry_in;
  logic          goes_after;
  logic          elig;

  // logical position to physical address in the ring
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(l);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // incoming descriptor with wrapped sequence time
  always_comb begin
    entry_in.tm     = send_time_i + offset_time_i;
    entry_in.sender = sender_id_i;
    entry_in.tag    = payload_tag_i;
    entry_in.size   = payload_size_i;
  end

  // stored entry must move one place up to make room
  assign goes_after = (rdata_i.tm > new_q.tm) ||
                      ((rdata_i.tm == new_q.tm) && (rdata_i.sender < new_q.sender));

  // entry just read qualifies for release
  assign elig = (idx_q < count_q) && (32'(idx_q) < MaxResults) && (rdata_i.tm < recv_q);

  assign busy_o  = (state_q != S_IDLE);
  assign count_o = count_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    head_d      = head_q;
    prev_d      = prev_q;
    recv_d      = recv_q;
    new_d       = new_q;
    k_d         = k_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pend_v_d    = pend_v_q;
    we_o        = 1'b0;
    waddr_o     = head_q;
    wdata_o     = new_q;
    re_o        = 1'b0;
    raddr_o     = head_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = KindAck;
    res_o.last  = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (req_type_i)
            REQ_INSERT: begin
              if (count_q == CW'(DEPTH)) begin
                res_valid_o  = 1'b1;
                res_o.status = StatusFull;
              end else if (count_q == '0) begin
                we_o        = 1'b1;
                waddr_o     = head_q;
                wdata_o     = entry_in;
                count_d     = count_q + CW'(1);
                res_valid_o = 1'b1;
              end else begin
                // walk back from the tail
                new_d   = entry_in;
                k_d     = AW'(count_q - CW'(1));
                re_o    = 1'b1;
                raddr_o = phys(head_q, count_q - CW'(1));
                state_d = S_INSERT;
              end
            end
            REQ_SERVICE: begin
              if (time_rolling_i && (recv_time_i != prev_q)) begin
                prev_d   = recv_time_i;
                recv_d   = recv_time_i;
                idx_d    = '0;
                pend_v_d = 1'b0;
                re_o     = 1'b1;
                raddr_o  = head_q;
                state_d  = S_RELEASE;
              end else begin
                res_valid_o = 1'b1;
              end
            end
            REQ_FLUSH: begin
              count_d     = '0;
              res_valid_o = 1'b1;
            end
            default: begin
              res_valid_o = 1'b1;
            end
          endcase
        end
      end

      S_INSERT: begin
        we_o    = 1'b1;
        waddr_o = phys(head_q, CW'(k_q) + CW'(1));
        if (goes_after) begin
          wdata_o = rdata_i;
          if (k_q == '0) begin
            state_d = S_PUT;
          end else begin
            k_d     = k_q - AW'(1);
            re_o    = 1'b1;
            raddr_o = phys(head_q, CW'(k_q) - CW'(1));
          end
        end else begin
          wdata_o     = new_q;
          count_d     = count_q + CW'(1);
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_PUT: begin
        we_o        = 1'b1;
        waddr_o     = head_q;
        wdata_o     = new_q;
        count_d     = count_q + CW'(1);
        res_valid_o = 1'b1;
        state_d     = S_IDLE;
      end

      S_RELEASE: begin
        // held entry goes out once we know whether another follows
        if (pend_v_q) begin
          res_valid_o  = 1'b1;
          res_o.kind   = KindRelease;
          res_o.status = StatusOk;
          res_o.sender = pend_q.sender;
          res_o.tag    = pend_q.tag;
          res_o.size   = pend_q.size;
          res_o.tm     = pend_q.tm;
          res_o.last   = !elig;
        end
        if (elig) begin
          pend_d   = rdata_i;
          pend_v_d = 1'b1;
          idx_d    = idx_q + CW'(1);
          re_o     = 1'b1;
          raddr_o  = phys(head_q, idx_q + CW'(1));
        end else begin
          head_d  = phys(head_q, idx_q);
          count_d = count_q - idx_q;
          if (!pend_v_q) begin
            res_valid_o = 1'b1;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      head_q   <= '0;
      prev_q   <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      head_q   <= head_d;
      prev_q   <= prev_d;
      pend_v_q <= pend_v_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    recv_q <= recv_d;
    new_q  <= new_d;
    k_q    <= k_d;
    idx_q  <= idx_d;
    pend_q <= pend_d;
  end

endmodule
